[src/configurable_crc_engine_unit_defines.svh]
// ----------------------------------------------------------------------------
// CRC engine assertion macros
// Property wrappers for the CRC engine checker.
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_CRC_ENGINE_UNIT_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_UNIT_DEFINES_SVH

// Clocked property, switched off while reset is asserted
`define CCE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked property, checked through reset as well
`define CCE_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cce_pkg.sv]
// ----------------------------------------------------------------------------
// CRC engine package
// Widths, reset values, register indexes and state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

  localparam int MAX_ORDER_DEF = 32;

  localparam int DATA_W   = 8;
  localparam int RESULT_W = 32;
  localparam int CFG_W    = 32;
  localparam int ORDER_W  = 6;
  localparam int IDX_W    = 3;

  localparam int CFG_NUM_REGS = 7;

  localparam logic [ORDER_W-1:0] RST_ORDER = 6'd24;
  localparam logic [CFG_W-1:0]   RST_POLY  = 32'h00FF_F409;
  localparam logic [CFG_W-1:0]   RST_START = 32'h0000_0000;
  localparam logic [CFG_W-1:0]   RST_XOR   = 32'h0000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_ORDER,
    REG_POLY,
    REG_START,
    REG_DIRECT,
    REG_XOR,
    REG_REFIN,
    REG_REFOUT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_CONV
  } state_t;

endpackage

`default_nettype wire

[src/configurable_crc_engine_unit.sv]
// A message's result is registered onto out_*, or into the skid stage if
// out_* stalls. Throughput: one byte per cycle, back to back, across
// messages, while the skid stage is empty. A register write goes through
// LOAD and, with an augmented start value, CONV (one zero-shift step per
// cycle); in_tready is low meanwhile. Synchronous active-low reset restores
// defaults (order 24, poly 0xFFF409) and a clear CRC, with no start-up pass.
// ----------------------------------------------------------------------------
// Configurable CRC engine
// Byte-serial CRC, Rocksoft-style parameters, order 1..MAX_ORDER.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module configurable_crc_engine_unit #(
  parameter int MAX_ORDER = cce_pkg::MAX_ORDER_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [cce_pkg::DATA_W-1:0]    in_tdata,   // data_byte
  input  wire logic                          in_tlast,   // last_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cce_pkg::RESULT_W-1:0]       out_tdata,  // crc_result
  input  wire logic                          cfg_we,
  input  wire logic [cce_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [cce_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int CNT_W = $clog2(MAX_ORDER);

  // configuration
  logic [cce_pkg::ORDER_W-1:0] order_r;
  logic [cce_pkg::CFG_W-1:0]   poly_r;
  logic [cce_pkg::CFG_W-1:0]   start_r;
  logic                        direct_r;
  logic [cce_pkg::CFG_W-1:0]   xor_r;
  logic                        refin_r;
  logic                        refout_r;
  logic                        cfg_hit;

  // control
  cce_pkg::state_t state_r, state_nxt;

  // datapath
  logic [MAX_ORDER-1:0] crc_r, crc_nxt;
  logic [MAX_ORDER-1:0] init_r, init_nxt;
  logic [MAX_ORDER-1:0] work_r, work_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [OW-1:0]        eff;
  logic [MAX_ORDER-1:0] mask;
  logic [MAX_ORDER-1:0] hb;
  logic [MAX_ORDER-1:0] poly_m;
  logic [MAX_ORDER-1:0] start_m;
  logic [MAX_ORDER-1:0] xor_m;
  logic [MAX_ORDER-1:0] step;
  logic [cce_pkg::DATA_W-1:0] din;
  logic [MAX_ORDER-1:0] crc_upd;
  logic [MAX_ORDER-1:0] crc_rev;
  logic [MAX_ORDER-1:0] res_full;
  logic [cce_pkg::RESULT_W-1:0] res;

  // output register and skid stage
  logic                         out_v_r, out_v_nxt;
  logic [cce_pkg::RESULT_W-1:0] out_d_r, out_d_nxt;
  logic                         skid_v_r, skid_v_nxt;
  logic [cce_pkg::RESULT_W-1:0] skid_d_r, skid_d_nxt;
  logic                         in_acc;
  logic                         out_take;

  function automatic logic [MAX_ORDER-1:0] shift_bit(
    input logic [MAX_ORDER-1:0] c,
    input logic                 d,
    input logic [MAX_ORDER-1:0] m,
    input logic [MAX_ORDER-1:0] top,
    input logic [MAX_ORDER-1:0] p
  );
    logic fb;
    fb = (|(c & top)) ^ d;
    return ((c << 1) & m) ^ (fb ? p : '0);
  endfunction

  // effective order, mask and top-bit select
  always_comb begin
    if (order_r == '0) begin
      eff = OW'(1);
    end else if (32'(order_r) > 32'(MAX_ORDER)) begin
      eff = OW'(MAX_ORDER);
    end else begin
      eff = OW'(order_r);
    end
    for (int i = 0; i < MAX_ORDER; i++) begin
      mask[i] = (OW'(i) < eff);
      hb[i]   = (OW'(i + 1) == eff);
    end
  end

  assign poly_m  = MAX_ORDER'(poly_r) & mask;
  assign start_m = MAX_ORDER'(start_r) & mask;
  assign xor_m   = MAX_ORDER'(xor_r) & mask;
  assign step    = shift_bit(work_r, 1'b0, mask, hb, poly_m);

  // byte update and finished result
  always_comb begin
    for (int b = 0; b < cce_pkg::DATA_W; b++) begin
      din[b] = refin_r ? in_tdata[cce_pkg::DATA_W-1-b] : in_tdata[b];
    end
    crc_upd = crc_r;
    for (int j = cce_pkg::DATA_W - 1; j >= 0; j--) begin
      crc_upd = shift_bit(crc_upd, din[j], mask, hb, poly_m);
    end
    for (int i = 0; i < MAX_ORDER; i++) begin
      crc_rev[i] = crc_upd[MAX_ORDER-1-i];
    end
    res_full = refout_r ? (crc_rev >> (OW'(MAX_ORDER) - eff)) : crc_upd;
    res_full = (res_full ^ xor_m) & mask;
    res      = cce_pkg::RESULT_W'(res_full);
  end

  // configuration writes
  always_comb begin
    case (cce_pkg::cfg_reg_t'(cfg_index))
      cce_pkg::REG_ORDER,
      cce_pkg::REG_POLY,
      cce_pkg::REG_START,
      cce_pkg::REG_DIRECT,
      cce_pkg::REG_XOR,
      cce_pkg::REG_REFIN,
      cce_pkg::REG_REFOUT: cfg_hit = cfg_we;
      default:             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= cce_pkg::RST_ORDER;
      poly_r   <= cce_pkg::RST_POLY;
      start_r  <= cce_pkg::RST_START;
      direct_r <= 1'b0;
      xor_r    <= cce_pkg::RST_XOR;
      refin_r  <= 1'b0;
      refout_r <= 1'b0;
    end else if (cfg_we) begin
      case (cce_pkg::cfg_reg_t'(cfg_index))
        cce_pkg::REG_ORDER:  order_r  <= cfg_wdata[cce_pkg::ORDER_W-1:0];
        cce_pkg::REG_POLY:   poly_r   <= cfg_wdata;
        cce_pkg::REG_START:  start_r  <= cfg_wdata;
        cce_pkg::REG_DIRECT: direct_r <= cfg_wdata[0];
        cce_pkg::REG_XOR:    xor_r    <= cfg_wdata;
        cce_pkg::REG_REFIN:  refin_r  <= cfg_wdata[0];
        cce_pkg::REG_REFOUT: refout_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // start value sequencer: next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_hit) begin
      state_nxt = cce_pkg::ST_LOAD;
    end else begin
      case (state_r)
        cce_pkg::ST_RUN:  state_nxt = cce_pkg::ST_RUN;
        cce_pkg::ST_LOAD: state_nxt = direct_r ? cce_pkg::ST_RUN : cce_pkg::ST_CONV;
        cce_pkg::ST_CONV: begin
          if ((OW'(cnt_r) + OW'(1)) == eff) begin
            state_nxt = cce_pkg::ST_RUN;
          end
        end
        default:          state_nxt = cce_pkg::ST_RUN;
      endcase
    end
  end

  // start value sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    case (state_r)
      cce_pkg::ST_RUN:  in_tready = !skid_v_r;
      cce_pkg::ST_LOAD: in_tready = 1'b0;
      cce_pkg::ST_CONV: in_tready = 1'b0;
      default:          in_tready = 1'b0;
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_take = out_v_r && out_tready;

  // CRC register, direct start value and zero-shift unit
  always_comb begin
    crc_nxt  = crc_r;
    init_nxt = init_r;
    work_nxt = work_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      cce_pkg::ST_RUN: begin
        if (in_acc) begin
          crc_nxt = in_tlast ? init_r : crc_upd;
        end
      end
      cce_pkg::ST_LOAD: begin
        work_nxt = start_m;
        cnt_nxt  = '0;
        if (direct_r) begin
          init_nxt = start_m;
          crc_nxt  = start_m;
        end
      end
      cce_pkg::ST_CONV: begin
        work_nxt = step;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if ((OW'(cnt_r) + OW'(1)) == eff) begin
          init_nxt = step;
          crc_nxt  = step;
        end
      end
      default: ;
    endcase
  end

  // result register with skid stage
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (out_take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (in_acc && in_tlast) begin
      if (!out_v_r || out_take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cce_pkg::ST_RUN;
      crc_r    <= '0;
      init_r   <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      crc_r    <= crc_nxt;
      init_r   <= init_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    cnt_r    <= cnt_nxt;
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

`default_nettype wire

[src/cce_checker.sv]
// ----------------------------------------------------------------------------
// CRC engine port checker
// Port-level properties of the CRC engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "configurable_crc_engine_unit_defines.svh"

module cce_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          in_tlast,   // last_byte
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cce_pkg::RESULT_W-1:0]  out_tdata,  // crc_result
  input wire logic                          cfg_we,
  input wire logic [cce_pkg::IDX_W-1:0]     cfg_index
);

  logic in_beat;
  logic cfg_valid_wr;

  assign in_beat      = in_tvalid && in_tready;
  assign cfg_valid_wr = cfg_we && (32'(cfg_index) < cce_pkg::CFG_NUM_REGS);

  `CCE_ASSERT(a_out_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)),
    "stalled result beat dropped or changed")

  `CCE_ASSERT_NORST(a_rst_clear, clk,
    !rst_n |=> !out_tvalid,
    "result valid after reset")

  `CCE_ASSERT(a_cfg_busy, clk, rst_n,
    cfg_valid_wr |=> !in_tready,
    "input accepted while start value is reloaded")

  `CCE_ASSERT(a_no_spurious, clk, rst_n,
    (in_beat && !in_tlast && !out_tvalid) |=> !out_tvalid,
    "result produced by a beat that does not end a message")

endmodule

bind configurable_crc_engine_unit cce_checker u_cce_checker (.*);

`default_nettype wire
